FILE: hdl/pcorr_pkg.sv
package pcorr_pkg;

   localparam int MAX_SAMPLES = 128;
   localparam int CNT_W = 8;
   localparam int XW = 24;
   localparam int PRODW = 2 * XW;
   localparam int SUM_W = 31;
   localparam int SQ_W = 54;
   localparam int MW = 64;
   localparam int PW = 2 * MW;
   localparam int MUL_CNT_W = 6;
   localparam int SW = 162;
   localparam int FRAC_SHIFT = 30;
   localparam int QB = 16;
   localparam int STEP_W = 4;
   localparam int CORR_W = 16;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDEF = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRUNC = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_SX2,
      OP_NSXX,
      OP_SY2,
      OP_NSYY,
      OP_SXSY,
      OP_NSXY,
      OP_VXVY,
      OP_CC
   } op_type;

   typedef struct packed {
      logic   take;
      logic   mul_go;
      logic   store;
      logic   search_step;
      logic   finish;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic zero_var;
   } sts_type;

endpackage

FILE: hdl/pcorr_mul.sv
module pcorr_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [pcorr_pkg::MW-1:0]   a,
   input  logic [pcorr_pkg::MW-1:0]   b,
   output logic                       done,
   output logic [pcorr_pkg::PW-1:0]   product
);

   logic [pcorr_pkg::PW-1:0]        acc_ff, acc_in;
   logic [pcorr_pkg::PW-1:0]        mcand_ff, mcand_in;
   logic [pcorr_pkg::MW-1:0]        mplier_ff, mplier_in;
   logic [pcorr_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            run_ff, run_in;
   logic                            done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (go) begin
         acc_in = '0;
         mcand_in = {{pcorr_pkg::MW{1'b0}}, a};
         mplier_in = b;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[pcorr_pkg::PW-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[pcorr_pkg::MW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pcorr_pkg::MUL_CNT_W'(pcorr_pkg::MW - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

FILE: hdl/pcorr_ctrl.sv
module pcorr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 last_sample,
   input  pcorr_pkg::sts_type   sts,
   output pcorr_pkg::cmd_type   cmd,
   output logic                 busy
);

   pcorr_pkg::state_type          state_ff, state_in;
   pcorr_pkg::op_type             op_ff, op_in;
   logic [pcorr_pkg::STEP_W-1:0]  step_ff, step_in;

   function automatic pcorr_pkg::op_type next_op(input pcorr_pkg::op_type op);
      case (op)
         pcorr_pkg::OP_SX2:  next_op = pcorr_pkg::OP_NSXX;
         pcorr_pkg::OP_NSXX: next_op = pcorr_pkg::OP_SY2;
         pcorr_pkg::OP_SY2:  next_op = pcorr_pkg::OP_NSYY;
         pcorr_pkg::OP_NSYY: next_op = pcorr_pkg::OP_SXSY;
         pcorr_pkg::OP_SXSY: next_op = pcorr_pkg::OP_NSXY;
         pcorr_pkg::OP_NSXY: next_op = pcorr_pkg::OP_VXVY;
         pcorr_pkg::OP_VXVY: next_op = pcorr_pkg::OP_CC;
         default:            next_op = pcorr_pkg::OP_SX2;
      endcase
   endfunction

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      step_in = step_ff;
      cmd = '0;
      cmd.op = op_ff;
      case (state_ff)
         pcorr_pkg::ST_IDLE: begin
            if (start) begin
               cmd.take = 1'b1;
               if (last_sample) begin
                  state_in = pcorr_pkg::ST_DRAIN;
                  op_in = pcorr_pkg::OP_SX2;
               end
            end
         end
         pcorr_pkg::ST_DRAIN: begin
            state_in = pcorr_pkg::ST_MUL_GO;
         end
         pcorr_pkg::ST_MUL_GO: begin
            cmd.mul_go = 1'b1;
            state_in = pcorr_pkg::ST_MUL_WAIT;
         end
         pcorr_pkg::ST_MUL_WAIT: begin
            if (sts.mul_done) begin
               cmd.store = 1'b1;
               case (op_ff)
                  pcorr_pkg::OP_NSXY: state_in = pcorr_pkg::ST_CHECK;
                  pcorr_pkg::OP_CC: begin
                     state_in = pcorr_pkg::ST_SEARCH;
                     step_in = '0;
                  end
                  default: begin
                     op_in = next_op(op_ff);
                     state_in = pcorr_pkg::ST_MUL_GO;
                  end
               endcase
            end
         end
         pcorr_pkg::ST_CHECK: begin
            if (sts.zero_var) begin
               state_in = pcorr_pkg::ST_DONE;
            end else begin
               op_in = pcorr_pkg::OP_VXVY;
               state_in = pcorr_pkg::ST_MUL_GO;
            end
         end
         pcorr_pkg::ST_SEARCH: begin
            cmd.search_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == pcorr_pkg::STEP_W'(pcorr_pkg::QB - 1)) begin
               state_in = pcorr_pkg::ST_DONE;
            end
         end
         pcorr_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = pcorr_pkg::ST_IDLE;
         end
         default: state_in = pcorr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcorr_pkg::ST_IDLE;
         op_ff <= pcorr_pkg::OP_SX2;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         step_ff <= step_in;
      end
   end

   assign busy = (state_ff != pcorr_pkg::ST_IDLE);

endmodule

FILE: hdl/pcorr_dp.sv
module pcorr_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcorr_pkg::cmd_type                     cmd,
   input  logic signed [pcorr_pkg::XW-1:0]        sample_x,
   input  logic signed [pcorr_pkg::XW-1:0]        sample_y,
   output pcorr_pkg::sts_type                     sts,
   output logic                                   rsp_valid,
   output logic signed [pcorr_pkg::CORR_W-1:0]    rsp_correlation,
   output logic [pcorr_pkg::STATUS_W-1:0]         rsp_status
);

   logic                                   s1_valid_ff;
   logic signed [pcorr_pkg::XW-1:0]        x_ff, y_ff;
   logic [pcorr_pkg::PRODW-1:0]            xx_ff, yy_ff;
   logic signed [pcorr_pkg::PRODW-1:0]     xy_ff;

   logic [pcorr_pkg::CNT_W-1:0]            count_ff;
   logic signed [pcorr_pkg::SUM_W-1:0]     sx_ff, sy_ff;
   logic [pcorr_pkg::SQ_W-1:0]             sxx_ff, syy_ff;
   logic signed [pcorr_pkg::SQ_W-1:0]      sxy_ff;
   logic                                   ovf_ff;

   logic [pcorr_pkg::MW-1:0]               t_ff, vx_ff, vy_ff, cmag_ff;
   logic                                   cneg_ff;
   logic [pcorr_pkg::PW-1:0]               p_ff;
   logic [pcorr_pkg::SW-1:0]               r_ff, u_ff, v_ff;
   logic [pcorr_pkg::QB-1:0]               m_ff;

   logic                                   rsp_valid_ff;
   logic signed [pcorr_pkg::CORR_W-1:0]    corr_ff;
   logic [pcorr_pkg::STATUS_W-1:0]         status_ff;

   logic [pcorr_pkg::SUM_W-1:0]            sx_mag, sy_mag;
   logic [pcorr_pkg::SQ_W-1:0]             sxy_mag;
   logic [pcorr_pkg::MW-1:0]               mul_a, mul_b;
   logic                                   mul_done;
   logic [pcorr_pkg::PW-1:0]               prod;
   logic [pcorr_pkg::MW-1:0]               prod_lo, term_a, term_b, cov;
   logic [pcorr_pkg::SW-1:0]               trial;
   logic                                   fits;
   logic [pcorr_pkg::QB:0]                 m_round;
   logic [pcorr_pkg::CORR_W-1:0]           k_mag;
   logic                                   zero_var;

   assign sx_mag = sx_ff[pcorr_pkg::SUM_W-1] ? -sx_ff : sx_ff;
   assign sy_mag = sy_ff[pcorr_pkg::SUM_W-1] ? -sy_ff : sy_ff;
   assign sxy_mag = sxy_ff[pcorr_pkg::SQ_W-1] ? -sxy_ff : sxy_ff;

   always_comb begin
      case (cmd.op)
         pcorr_pkg::OP_SX2: begin
            mul_a = pcorr_pkg::MW'(sx_mag);
            mul_b = pcorr_pkg::MW'(sx_mag);
         end
         pcorr_pkg::OP_NSXX: begin
            mul_a = pcorr_pkg::MW'(count_ff);
            mul_b = pcorr_pkg::MW'(sxx_ff);
         end
         pcorr_pkg::OP_SY2: begin
            mul_a = pcorr_pkg::MW'(sy_mag);
            mul_b = pcorr_pkg::MW'(sy_mag);
         end
         pcorr_pkg::OP_NSYY: begin
            mul_a = pcorr_pkg::MW'(count_ff);
            mul_b = pcorr_pkg::MW'(syy_ff);
         end
         pcorr_pkg::OP_SXSY: begin
            mul_a = pcorr_pkg::MW'(sx_mag);
            mul_b = pcorr_pkg::MW'(sy_mag);
         end
         pcorr_pkg::OP_NSXY: begin
            mul_a = pcorr_pkg::MW'(count_ff);
            mul_b = pcorr_pkg::MW'(sxy_mag);
         end
         pcorr_pkg::OP_VXVY: begin
            mul_a = vx_ff;
            mul_b = vy_ff;
         end
         default: begin
            mul_a = cmag_ff;
            mul_b = cmag_ff;
         end
      endcase
   end

   pcorr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   assign prod_lo = prod[pcorr_pkg::MW-1:0];
   assign term_a = sxy_ff[pcorr_pkg::SQ_W-1] ? -prod_lo : prod_lo;
   assign term_b = (sx_ff[pcorr_pkg::SUM_W-1] ^ sy_ff[pcorr_pkg::SUM_W-1]) ? -t_ff : t_ff;
   assign cov = term_a - term_b;

   assign trial = u_ff + v_ff;
   assign fits = (trial <= r_ff);

   assign m_round = {1'b0, m_ff} + 1'b1;
   assign k_mag = m_round[pcorr_pkg::QB:1];

   assign zero_var = (vx_ff == '0) || (vy_ff == '0);
   assign sts.mul_done = mul_done;
   assign sts.zero_var = zero_var;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.take;
      end
      if (cmd.take) begin
         x_ff <= sample_x;
         y_ff <= sample_y;
         xx_ff <= pcorr_pkg::PRODW'(sample_x * sample_x);
         yy_ff <= pcorr_pkg::PRODW'(sample_y * sample_y);
         xy_ff <= sample_x * sample_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         count_ff <= '0;
         sx_ff <= '0;
         sy_ff <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         if (count_ff < pcorr_pkg::CNT_W'(pcorr_pkg::MAX_SAMPLES)) begin
            count_ff <= count_ff + 1'b1;
            sx_ff <= sx_ff + pcorr_pkg::SUM_W'(x_ff);
            sy_ff <= sy_ff + pcorr_pkg::SUM_W'(y_ff);
            sxx_ff <= sxx_ff + pcorr_pkg::SQ_W'(xx_ff);
            syy_ff <= syy_ff + pcorr_pkg::SQ_W'(yy_ff);
            sxy_ff <= sxy_ff + pcorr_pkg::SQ_W'(xy_ff);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.op)
            pcorr_pkg::OP_SX2, pcorr_pkg::OP_SY2, pcorr_pkg::OP_SXSY: t_ff <= prod_lo;
            pcorr_pkg::OP_NSXX: vx_ff <= prod_lo - t_ff;
            pcorr_pkg::OP_NSYY: vy_ff <= prod_lo - t_ff;
            pcorr_pkg::OP_NSXY: begin
               cneg_ff <= cov[pcorr_pkg::MW-1];
               cmag_ff <= cov[pcorr_pkg::MW-1] ? -cov : cov;
            end
            pcorr_pkg::OP_VXVY: p_ff <= prod;
            default: begin
               r_ff <= pcorr_pkg::SW'(prod) << pcorr_pkg::FRAC_SHIFT;
               v_ff <= pcorr_pkg::SW'(p_ff) << pcorr_pkg::FRAC_SHIFT;
               u_ff <= '0;
               m_ff <= '0;
            end
         endcase
      end else if (cmd.search_step) begin
         m_ff <= {m_ff[pcorr_pkg::QB-2:0], fits};
         v_ff <= v_ff >> 2;
         if (fits) begin
            r_ff <= r_ff - trial;
            u_ff <= (u_ff + (v_ff << 1)) >> 1;
         end else begin
            u_ff <= u_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         if (zero_var) begin
            corr_ff <= '0;
            status_ff <= pcorr_pkg::STATUS_UNDEF;
         end else begin
            corr_ff <= cneg_ff ? -k_mag : k_mag;
            status_ff <= ovf_ff ? pcorr_pkg::STATUS_TRUNC : pcorr_pkg::STATUS_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_correlation = corr_ff;
   assign rsp_status = status_ff;

endmodule

FILE: hdl/pearson_correlation.sv
// Channel   Handshake           Payload
// request   start / busy        req_sample_x, req_sample_y, req_last_sample
// response  rsp_valid (strobe)  rsp_correlation, rsp_status
//
// Pairs are taken one per cycle while busy is low; the first 128 beats are summed in
// the cycle after. After the beat marked last, busy stays high for eight products on
// the shared shift-add multiplier and 16 search steps (six products on zero variance).
// The result is driven for one cycle as busy falls; the receiver cannot stall it.
// Reset is synchronous and clears all sums and the controller.
module pearson_correlation (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [pcorr_pkg::XW-1:0]        req_sample_x,
   input  logic signed [pcorr_pkg::XW-1:0]        req_sample_y,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   output logic signed [pcorr_pkg::CORR_W-1:0]    rsp_correlation,
   output logic [pcorr_pkg::STATUS_W-1:0]         rsp_status
);

   pcorr_pkg::cmd_type cmd;
   pcorr_pkg::sts_type sts;

   pcorr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_sample (req_last_sample),
      .sts         (sts),
      .cmd         (cmd),
      .busy        (busy)
   );

   pcorr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sample_x        (req_sample_x),
      .sample_y        (req_sample_y),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_correlation (rsp_correlation),
      .rsp_status      (rsp_status)
   );

`ifndef ASSERT_OFF
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result without a preceding busy period");

   a_busy_on_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_last_sample))
      else $error("busy rose without a last beat");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pcorr_pkg::STATUS_UNDEF |-> rsp_correlation == '0)
      else $error("undefined result carries a nonzero coefficient");
`endif

endmodule

FILE: bench/pearson_correlation_tb.sv
module pearson_correlation_tb;

   localparam int N_RANDOM = 2000;
   localparam int N_ROWS = 22;
   localparam longint CYCLE_LIMIT = 6000000;
   localparam int DRAIN_WAIT = 700;

   typedef struct {
      logic signed [pcorr_pkg::CORR_W-1:0] corr;
      logic [pcorr_pkg::STATUS_W-1:0]      status;
   } corr_result_type;

   typedef struct {
      int  x;
      int  y;
      bit  last;
      bit  typed;
      int  corr;
      logic [pcorr_pkg::STATUS_W-1:0] status;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [pcorr_pkg::XW-1:0] req_sample_x = 0;
   logic signed [pcorr_pkg::XW-1:0] req_sample_y = 0;
   logic req_last_sample = 0;
   logic rsp_valid;
   logic signed [pcorr_pkg::CORR_W-1:0] rsp_correlation;
   logic [pcorr_pkg::STATUS_W-1:0] rsp_status;

   bit typed_valid = 0;
   corr_result_type typed_result = '{0, pcorr_pkg::STATUS_OK};

   logic [pcorr_pkg::CNT_W-1:0] n_pairs;
   logic signed [pcorr_pkg::SUM_W-1:0] acc_x, acc_y;
   logic [pcorr_pkg::SQ_W-1:0] acc_xx, acc_yy;
   logic signed [pcorr_pkg::SQ_W-1:0] acc_xy;
   bit truncated;

   corr_result_type expected_corr[$];
   int errors = 0;
   longint cycles = 0;

   pearson_correlation dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic corr_result_type take_pair(logic signed [pcorr_pkg::XW-1:0] x,
                                                 logic signed [pcorr_pkg::XW-1:0] y,
                                                 bit last);
      corr_result_type res;
      longint n, vx, vy, cov, mag, sxl, syl;
      logic [191:0] lhs, prod, rhs;
      int lo, hi, mid;
      longint odd;
      res = '{0, pcorr_pkg::STATUS_OK};
      if (n_pairs < pcorr_pkg::MAX_SAMPLES) begin
         n_pairs = n_pairs + 1'b1;
         acc_x = acc_x + pcorr_pkg::SUM_W'(x);
         acc_y = acc_y + pcorr_pkg::SUM_W'(y);
         acc_xx = acc_xx + pcorr_pkg::SQ_W'(longint'(x) * longint'(x));
         acc_yy = acc_yy + pcorr_pkg::SQ_W'(longint'(y) * longint'(y));
         acc_xy = acc_xy + pcorr_pkg::SQ_W'(longint'(x) * longint'(y));
      end else begin
         truncated = 1;
      end
      if (!last) return res;
      n = longint'(n_pairs);
      sxl = longint'(acc_x);
      syl = longint'(acc_y);
      vx = n * longint'(acc_xx) - sxl * sxl;
      vy = n * longint'(acc_yy) - syl * syl;
      cov = n * longint'(acc_xy) - sxl * syl;
      if (vx == 0 || vy == 0) begin
         res = '{0, pcorr_pkg::STATUS_UNDEF};
      end else begin
         mag = cov < 0 ? -cov : cov;
         lhs = (192'(mag) * 192'(mag)) << 30;
         prod = 192'(vx) * 192'(vy);
         lo = 0;
         hi = 16384;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * mid - 1;
            rhs = prod * 192'(odd * odd);
            if (lhs >= rhs) lo = mid;
            else hi = mid - 1;
         end
         res.corr = pcorr_pkg::CORR_W'(cov < 0 ? -lo : lo);
         res.status = truncated ? pcorr_pkg::STATUS_TRUNC : pcorr_pkg::STATUS_OK;
      end
      n_pairs = '0;
      acc_x = '0;
      acc_y = '0;
      acc_xx = '0;
      acc_yy = '0;
      acc_xy = '0;
      truncated = 0;
      return res;
   endfunction

   always @(posedge clock) begin
      corr_result_type pred, got;
      if (reset) begin
         n_pairs = '0;
         acc_x = '0;
         acc_y = '0;
         acc_xx = '0;
         acc_yy = '0;
         acc_xy = '0;
         truncated = 0;
      end else begin
         if (start && !busy) begin
            pred = take_pair(req_sample_x, req_sample_y, req_last_sample);
            if (req_last_sample) expected_corr.push_back(typed_valid ? typed_result : pred);
         end
         if (rsp_valid) begin
            if (expected_corr.size() == 0) begin
               errors++;
               if (errors <= 10) $display("Unexpected result corr=%0d status=%0d",
                                          rsp_correlation, rsp_status);
            end else begin
               got = expected_corr.pop_front();
               if (got.corr !== rsp_correlation || got.status !== rsp_status) begin
                  errors++;
                  if (errors <= 10)
                     $display("Mismatch: expected corr=%0d status=%0d, got corr=%0d status=%0d",
                              got.corr, got.status, rsp_correlation, rsp_status);
               end
            end
         end
      end
   end

   task automatic send(int x, int y, bit last, bit typed = 0, int corr = 0,
                       logic [pcorr_pkg::STATUS_W-1:0] status = pcorr_pkg::STATUS_OK);
      req_sample_x <= pcorr_pkg::XW'(x);
      req_sample_y <= pcorr_pkg::XW'(y);
      req_last_sample <= last;
      typed_valid <= typed;
      typed_result <= '{pcorr_pkg::CORR_W'(corr), status};
      start <= 1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   task automatic maybe_gap(ref int burst);
      int gap;
      if (burst > 0) begin
         burst--;
         return;
      end
      burst = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int rand24();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 8388607 : -8388608;
         1: return int'($urandom_range(0, 200)) - 100;
         default: return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
      endcase
   endfunction

   stim_row_type rows[N_ROWS] = '{
      '{5, 7, 1, 1, 0, pcorr_pkg::STATUS_UNDEF},
      '{1, 1, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{2, 2, 1, 1, 16384, pcorr_pkg::STATUS_OK},
      '{1, 2, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{2, 1, 1, 1, -16384, pcorr_pkg::STATUS_OK},
      '{-8388608, -8388608, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{8388607, 8388607, 1, 1, 16384, pcorr_pkg::STATUS_OK},
      '{-8388608, 8388607, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{8388607, -8388608, 1, 1, -16384, pcorr_pkg::STATUS_OK},
      '{3, 1, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{3, 2, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{3, 9, 1, 1, 0, pcorr_pkg::STATUS_UNDEF},
      '{0, 0, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{1, 0, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{2, 5, 1, 0, 0, pcorr_pkg::STATUS_OK},
      '{0, 1, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{1, 0, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{2, 2, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{5, -3, 1, 0, 0, pcorr_pkg::STATUS_OK},
      '{-8388608, 8388607, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{8388607, -1, 0, 0, 0, pcorr_pkg::STATUS_OK},
      '{12345, 4242, 1, 0, 0, pcorr_pkg::STATUS_OK}
   };

   initial begin
      int sent, len, burst, mode, x, y, a;
      burst = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         send(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].corr,
              rows[i].status);
         maybe_gap(burst);
      end
      start <= 0;
      typed_valid <= 0;
      while (expected_corr.size() != 0) @(posedge clock);
      sent = 0;
      while (sent < N_RANDOM) begin
         case ($urandom_range(0, 19))
            0: len = 1;
            1: len = $urandom_range(128, 136);
            2: len = 128;
            default: len = $urandom_range(2, 24);
         endcase
         mode = $urandom_range(0, 5);
         a = int'($urandom_range(0, 6)) - 3;
         for (int k = 0; k < len; k++) begin
            x = rand24();
            case (mode)
               0: y = 77;
               1: begin
                  x = int'($urandom_range(0, 2000)) - 1000;
                  y = a * x + int'($urandom_range(0, 8)) - 4;
               end
               2: y = x;
               default: y = rand24();
            endcase
            send(x, y, k == len - 1);
            sent++;
            maybe_gap(burst);
         end
      end
      start <= 0;
      while (expected_corr.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: sim.f
hdl/pcorr_pkg.sv
hdl/pcorr_mul.sv
hdl/pcorr_ctrl.sv
hdl/pcorr_dp.sv
hdl/pearson_correlation.sv
bench/pearson_correlation_tb.sv
